FILE: src/gme_pkg.sv
// shared types and constants of the gaussian membership evaluator
package gme_pkg;

	localparam int SAMPLE_W = 32;
	localparam int MEMB_W   = 24;
	localparam int CFG_IW   = 3;
	localparam int CFG_DW   = 32;
	localparam int E_W      = 22;
	localparam int SQ_W     = 48;
	localparam int TAB_W    = 31;

	localparam logic [CFG_IW-1:0] REG_CENTER       = 3'd0;
	localparam logic [CFG_IW-1:0] REG_INV_TWO_SIG2 = 3'd1;
	localparam logic [CFG_IW-1:0] REG_AMPLITUDE    = 3'd2;
	localparam logic [CFG_IW-1:0] REG_SUPPORT_LOW  = 3'd3;
	localparam logic [CFG_IW-1:0] REG_SUPPORT_HIGH = 3'd4;

	localparam logic [31:0] RST_CENTER       = 32'd0;
	localparam logic [31:0] RST_INV_TWO_SIG2 = 32'd32768;
	localparam logic [23:0] RST_AMPLITUDE    = 24'd26145;
	localparam logic [31:0] RST_SUPPORT_LOW  = 32'hFFFA_EBBE;
	localparam logic [31:0] RST_SUPPORT_HIGH = 32'h0005_1442;

	// exponent cap of 32.0 in q16.16
	localparam logic [63:0] E_CAP     = 64'd1 << 21;
	localparam logic [16:0] LOG2E_Q16 = 17'd94548;
	localparam logic [63:0] LN2_Q32   = 64'd2977044472;
	localparam logic [6:0]  N_LIMIT   = 7'd31;

	typedef struct packed {
		logic signed [31:0] center;
		logic [31:0]        inv_two_sigma_sq;
		logic [23:0]        amplitude;
		logic signed [31:0] support_low;
		logic signed [31:0] support_high;
	} cfg_regs_t;

	typedef struct packed {
		logic           vld;
		logic [E_W-1:0] e;
		logic           ins;
	} front_res_t;

	typedef struct packed {
		logic              vld;
		logic [MEMB_W-1:0] membership;
		logic              ins;
	} exp_res_t;

endpackage

FILE: src/gme_ifs.sv
// stream and configuration channel interfaces
interface gme_sample_if;
	logic                                valid;
	logic                                ready;
	logic signed [gme_pkg::SAMPLE_W-1:0] sample;
	modport source(output valid, output sample, input ready);
	modport sink(input valid, input sample, output ready);
endinterface

interface gme_result_if;
	logic                        valid;
	logic                        ready;
	logic [gme_pkg::MEMB_W-1:0]  membership;
	logic                        in_support;
	modport source(output valid, output membership, output in_support, input ready);
	modport sink(input valid, input membership, input in_support, output ready);
endinterface

interface gme_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [gme_pkg::CFG_IW-1:0] index;
	logic [gme_pkg::CFG_DW-1:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

FILE: src/gaussian_membership_eval_unit.sv
// top level: configuration registers, pipeline control and the two datapath halves
//
//  channel   modport  fields                       role
//  samples   sink     sample                       one x in signed q16.16 per request
//  results   source   membership, in_support       one result per sample, in order
//  cfg       sink     index, data                  register writes, always ready
//
// one sample per cycle unless a waiting result stalls; an accepted request passes
// register stages for distance, square, scale, base-2 split, table, interpolation
// and amplitude. reset clears the stage valid bits and loads the register defaults.
// a waiting result with results.ready low freezes all stages at once; samples.ready
// follows results.ready while the last stage holds a result.
module gaussian_membership_eval_unit #(
	parameter int EXP_TABLE_DEPTH = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	gme_sample_if.sink   samples,
	gme_result_if.source results,
	gme_cfg_if.sink      cfg
);

	gme_pkg::cfg_regs_t  regs_q;
	gme_pkg::front_res_t front_res;
	gme_pkg::exp_res_t   exp_res;
	logic                adv;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.center           <= gme_pkg::RST_CENTER;
			regs_q.inv_two_sigma_sq <= gme_pkg::RST_INV_TWO_SIG2;
			regs_q.amplitude        <= gme_pkg::RST_AMPLITUDE;
			regs_q.support_low      <= gme_pkg::RST_SUPPORT_LOW;
			regs_q.support_high     <= gme_pkg::RST_SUPPORT_HIGH;
		end else if (cfg.valid) begin
			case (cfg.index)
				gme_pkg::REG_CENTER:       regs_q.center           <= cfg.data;
				gme_pkg::REG_INV_TWO_SIG2: regs_q.inv_two_sigma_sq <= cfg.data;
				gme_pkg::REG_AMPLITUDE:    regs_q.amplitude        <= cfg.data[23:0];
				gme_pkg::REG_SUPPORT_LOW:  regs_q.support_low      <= cfg.data;
				gme_pkg::REG_SUPPORT_HIGH: regs_q.support_high     <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// whole pipeline moves unless the output holds a result nobody takes
	assign adv           = !exp_res.vld || results.ready;
	assign samples.ready = adv;

	gme_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.in_vld (samples.valid),
		.sample (samples.sample),
		.cfg    (regs_q),
		.res    (front_res)
	);

	gme_exp #(
		.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
	) u_exp (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.din       (front_res),
		.amplitude (regs_q.amplitude),
		.res       (exp_res)
	);

	assign results.valid      = exp_res.vld;
	assign results.membership = exp_res.membership;
	assign results.in_support = exp_res.ins;

endmodule

FILE: src/gme_front.sv
// stages 1 to 3: distance to center, square, scaling into the exponent
module gme_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                adv,
	input  logic                                in_vld,
	input  logic signed [gme_pkg::SAMPLE_W-1:0] sample,
	input  gme_pkg::cfg_regs_t                  cfg,
	output gme_pkg::front_res_t                 res
);

	logic [32:0]              diff;
	logic [31:0]              mag;
	logic                     ins;
	logic [63:0]              sq_full;
	logic [63:0]              p1;
	logic [63:0]              p2;
	logic [63:0]              e_sum;
	logic [gme_pkg::E_W-1:0]  e_next;

	logic                     vld_s1, vld_s2, vld_s3;
	logic [31:0]              mag_s1;
	logic                     ins_s1, ins_s2, ins_s3;
	logic [gme_pkg::SQ_W-1:0] sq_s2;
	logic [gme_pkg::E_W-1:0]  e_s3;

	always_comb begin
		diff = {sample[31], sample} - {cfg.center[31], cfg.center};
		mag  = diff[32] ? 32'(-diff) : diff[31:0];
		ins  = (sample >= cfg.support_low) && (sample <= cfg.support_high);
	end

	assign sq_full = 64'(mag_s1) * 64'(mag_s1);

	// integer and fraction halves of k multiplied apart, each checked against the cap
	always_comb begin
		p1    = 64'(sq_s2) * 64'(cfg.inv_two_sigma_sq[31:16]);
		p2    = (64'(sq_s2) * 64'(cfg.inv_two_sigma_sq[15:0])) >> 16;
		e_sum = p1 + p2;
		if (p1 >= gme_pkg::E_CAP || p2 >= gme_pkg::E_CAP) begin
			e_next = gme_pkg::E_W'(gme_pkg::E_CAP);
		end else if (e_sum > gme_pkg::E_CAP) begin
			e_next = gme_pkg::E_W'(gme_pkg::E_CAP);
		end else begin
			e_next = gme_pkg::E_W'(e_sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s1 <= mag;
			ins_s1 <= ins;
			sq_s2  <= sq_full[16 +: gme_pkg::SQ_W];
			ins_s2 <= ins_s1;
			e_s3   <= e_next;
			ins_s3 <= ins_s2;
		end
	end

	assign res.vld = vld_s3;
	assign res.e   = e_s3;
	assign res.ins = ins_s3;

endmodule

FILE: src/gme_exp.sv
// stages 4 to 7: base-2 reduction, table interpolation, amplitude scaling
module gme_exp #(
	parameter int EXP_TABLE_DEPTH = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  gme_pkg::front_res_t        din,
	input  logic [gme_pkg::MEMB_W-1:0] amplitude,
	output gme_pkg::exp_res_t          res
);

	localparam int IW = $clog2(EXP_TABLE_DEPTH);
	localparam int TW = $clog2(EXP_TABLE_DEPTH + 1);
	localparam int PW = 16 + IW;

	typedef logic [gme_pkg::TAB_W-1:0] tab_t [0:EXP_TABLE_DEPTH];

	// 2^(-i/depth) in q1.30 from a 15-term series in q32
	function automatic tab_t build_tab();
		tab_t        tab;
		logic [63:0] x;
		logic [63:0] y;
		logic [63:0] term;
		logic [63:0] acc;
		for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
			x    = (64'(i) << 32) / EXP_TABLE_DEPTH;
			y    = (x * gme_pkg::LN2_Q32) >> 32;
			term = 64'd1 << 32;
			acc  = term;
			for (int k = 1; k <= 14; k++) begin
				term = ((term * y) >> 32) / 64'(k);
				if (k % 2 == 1) begin
					acc = acc - term;
				end else begin
					acc = acc + term;
				end
			end
			tab[i] = gme_pkg::TAB_W'((acc + 64'd2) >> 2);
		end
		return tab;
	endfunction

	localparam tab_t POW2_TAB = build_tab();

	logic [38:0]                t_full;
	logic [6:0]                 n_int;
	logic [PW-1:0]              pos;
	logic [IW-1:0]              idx;
	logic [gme_pkg::TAB_W-1:0]  base;
	logic [gme_pkg::TAB_W-1:0]  step;
	logic [46:0]                interp;
	logic [gme_pkg::TAB_W-1:0]  v;
	logic [54:0]                prod;
	logic [24:0]                m_raw;
	logic [gme_pkg::MEMB_W-1:0] m_sat;

	logic                       vld_s4, vld_s5, vld_s6, vld_s7;
	logic                       ins_s4, ins_s5, ins_s6, ins_s7;
	logic                       kill_s4, kill_s5, kill_s6;
	logic [15:0]                f_s4, w_s5;
	logic [4:0]                 n_s4, n_s5;
	logic [gme_pkg::TAB_W-1:0]  base_s5, step_s5, g_s6;
	logic [gme_pkg::MEMB_W-1:0] memb_s7;

	always_comb begin
		t_full = 39'(din.e) * 39'(gme_pkg::LOG2E_Q16);
		n_int  = t_full[38:32];
	end

	always_comb begin
		pos  = PW'(f_s4) * PW'(EXP_TABLE_DEPTH);
		idx  = pos[16 +: IW];
		base = POW2_TAB[TW'(idx)];
		step = base - POW2_TAB[TW'(idx) + TW'(1)];
	end

	always_comb begin
		interp = 47'(step_s5) * 47'(w_s5);
		v      = base_s5 - gme_pkg::TAB_W'(interp >> 16);
	end

	// round half up, clamp to the q8.16 maximum
	always_comb begin
		prod  = 55'(amplitude) * 55'(g_s6) + (55'(1) << 29);
		m_raw = prod[54:30];
		m_sat = m_raw[24] ? '1 : m_raw[gme_pkg::MEMB_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= din.vld;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s4    <= t_full[31:16];
			n_s4    <= n_int[4:0];
			kill_s4 <= n_int >= gme_pkg::N_LIMIT;
			ins_s4  <= din.ins;
			base_s5 <= base;
			step_s5 <= step;
			w_s5    <= pos[15:0];
			n_s5    <= n_s4;
			kill_s5 <= kill_s4;
			ins_s5  <= ins_s4;
			g_s6    <= v >> n_s5;
			kill_s6 <= kill_s5;
			ins_s6  <= ins_s5;
			memb_s7 <= kill_s6 ? '0 : m_sat;
			ins_s7  <= ins_s6;
		end
	end

	assign res.vld        = vld_s7;
	assign res.membership = memb_s7;
	assign res.ins        = ins_s7;

endmodule
